// ===== rtl/eight_bit_cpu_alu_with_flags_core_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the eight-bit ALU core
// Immediate (|->) and next-cycle (|=>) implication checks, reset-qualified.
// ----------------------------------------------------------------------------
`ifndef EIGHT_BIT_CPU_ALU_WITH_FLAGS_CORE_DEFINES_SVH
`define EIGHT_BIT_CPU_ALU_WITH_FLAGS_CORE_DEFINES_SVH

`ifndef SYNTHESIS

`define EBA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("eba assertion failed");

`define EBA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("eba assertion failed");

`else

`define EBA_ASSERT_IMP(lbl, clk, rstn, ante, cons)

`define EBA_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ===== rtl/eba_pkg.sv =====
// ----------------------------------------------------------------------------
// eba_pkg
// Item types and operation codes of the eight-bit ALU core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package eba_pkg;

  typedef enum logic [4:0] {
    MODE_ADD  = 5'd0,
    MODE_ADC  = 5'd1,
    MODE_SUB  = 5'd2,
    MODE_SBC  = 5'd3,
    MODE_AND  = 5'd4,
    MODE_XOR  = 5'd5,
    MODE_OR   = 5'd6,
    MODE_CP   = 5'd7,
    MODE_INC  = 5'd8,
    MODE_DEC  = 5'd9,
    MODE_RLCA = 5'd10,
    MODE_RRCA = 5'd11,
    MODE_RLA  = 5'd12,
    MODE_RRA  = 5'd13,
    MODE_DAA  = 5'd14,
    MODE_CPL  = 5'd15,
    MODE_SCF  = 5'd16,
    MODE_CCF  = 5'd17,
    MODE_RLC  = 5'd18,
    MODE_RRC  = 5'd19,
    MODE_RL   = 5'd20,
    MODE_RR   = 5'd21,
    MODE_SLA  = 5'd22,
    MODE_SRA  = 5'd23,
    MODE_SWAP = 5'd24,
    MODE_SRL  = 5'd25,
    MODE_BIT  = 5'd26,
    MODE_RES  = 5'd27,
    MODE_SET  = 5'd28
  } eba_mode_e;

  localparam logic [7:0] DAA_LIMIT = 8'h99;
  localparam logic [3:0] DAA_NIB   = 4'h6;
  localparam logic [3:0] BCD_MAX   = 4'h9;

  typedef struct packed {
    logic [4:0] mode;
    logic [7:0] acc;
    logic [7:0] operand;
    logic [2:0] bit_index;
    logic       zero_in;
    logic       sub_in;
    logic       half_in;
    logic       carry_in;
  } eba_in_t;

  typedef struct packed {
    logic [7:0] result;
    logic       write_back;
    logic       zero_out;
    logic       sub_out;
    logic       half_out;
    logic       carry_out;
  } eba_out_t;

endpackage

// ===== rtl/eba_alu.sv =====
// ----------------------------------------------------------------------------
// eba_alu
// Combinational datapath: result byte, write-back mark and new Z/N/H/C flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module eba_alu (
  input  eba_pkg::eba_in_t  op_i,
  output eba_pkg::eba_out_t res_o
);
  import eba_pkg::*;

  logic [7:0] a, d;
  logic       z, n, h, c;
  logic       cin;
  logic [8:0] add_w, sub_w;
  logic [4:0] add_h, sub_h;
  logic [7:0] inc_w, dec_w;
  logic [7:0] bit_mask;
  logic       daa_lo, daa_hi;
  logic [7:0] daa_corr, daa_w;
  logic [7:0] r;
  logic       wb, zf, nf, hf, cf;
  logic       z_from_r;

  assign a = op_i.acc;
  assign d = op_i.operand;
  assign z = op_i.zero_in;
  assign n = op_i.sub_in;
  assign h = op_i.half_in;
  assign c = op_i.carry_in;

  assign cin   = ((op_i.mode == MODE_ADC) || (op_i.mode == MODE_SBC)) ? c : 1'b0;
  assign add_w = {1'b0, a} + {1'b0, d} + {8'd0, cin};
  assign add_h = {1'b0, a[3:0]} + {1'b0, d[3:0]} + {4'd0, cin};
  assign sub_w = {1'b0, a} - {1'b0, d} - {8'd0, cin};
  assign sub_h = {1'b0, a[3:0]} - {1'b0, d[3:0]} - {4'd0, cin};
  assign inc_w = d + 8'd1;
  assign dec_w = d - 8'd1;

  assign bit_mask = 8'd1 << op_i.bit_index;

  assign daa_lo   = n ? h : (h || (a[3:0] > BCD_MAX));
  assign daa_hi   = n ? c : (c || (a > DAA_LIMIT));
  assign daa_corr = {(daa_hi ? DAA_NIB : 4'h0), (daa_lo ? DAA_NIB : 4'h0)};
  assign daa_w    = n ? (a - daa_corr) : (a + daa_corr);

  always_comb begin
    r        = d;
    wb       = 1'b1;
    zf       = z;
    nf       = 1'b0;
    hf       = 1'b0;
    cf       = c;
    z_from_r = 1'b1;
    unique case (op_i.mode)
      MODE_ADD, MODE_ADC: begin
        r  = add_w[7:0];
        cf = add_w[8];
        hf = add_h[4];
      end
      MODE_SUB, MODE_SBC: begin
        r  = sub_w[7:0];
        nf = 1'b1;
        cf = sub_w[8];
        hf = sub_h[4];
      end
      MODE_CP: begin
        r  = a;
        wb = 1'b0;
        zf = (sub_w[7:0] == 8'd0);
        z_from_r = 1'b0;
        nf = 1'b1;
        cf = sub_w[8];
        hf = sub_h[4];
      end
      MODE_AND: begin
        r  = a & d;
        hf = 1'b1;
        cf = 1'b0;
      end
      MODE_XOR: begin
        r  = a ^ d;
        cf = 1'b0;
      end
      MODE_OR: begin
        r  = a | d;
        cf = 1'b0;
      end
      MODE_INC: begin
        r  = inc_w;
        hf = (d[3:0] == 4'hF);
      end
      MODE_DEC: begin
        r  = dec_w;
        nf = 1'b1;
        hf = (d[3:0] == 4'h0);
      end
      MODE_RLCA: begin
        r  = {a[6:0], a[7]};
        cf = a[7];
        zf = 1'b0;
        z_from_r = 1'b0;
      end
      MODE_RRCA: begin
        r  = {a[0], a[7:1]};
        cf = a[0];
        zf = 1'b0;
        z_from_r = 1'b0;
      end
      MODE_RLA: begin
        r  = {a[6:0], c};
        cf = a[7];
        zf = 1'b0;
        z_from_r = 1'b0;
      end
      MODE_RRA: begin
        r  = {c, a[7:1]};
        cf = a[0];
        zf = 1'b0;
        z_from_r = 1'b0;
      end
      MODE_DAA: begin
        r  = daa_w;
        nf = n;
        cf = daa_hi;
      end
      MODE_CPL: begin
        r  = ~a;
        nf = 1'b1;
        hf = 1'b1;
        z_from_r = 1'b0;
      end
      MODE_SCF: begin
        r  = a;
        wb = 1'b0;
        cf = 1'b1;
        z_from_r = 1'b0;
      end
      MODE_CCF: begin
        r  = a;
        wb = 1'b0;
        cf = ~c;
        z_from_r = 1'b0;
      end
      MODE_RLC: begin
        r  = {d[6:0], d[7]};
        cf = d[7];
      end
      MODE_RRC: begin
        r  = {d[0], d[7:1]};
        cf = d[0];
      end
      MODE_RL: begin
        r  = {d[6:0], c};
        cf = d[7];
      end
      MODE_RR: begin
        r  = {c, d[7:1]};
        cf = d[0];
      end
      MODE_SLA: begin
        r  = {d[6:0], 1'b0};
        cf = d[7];
      end
      MODE_SRA: begin
        r  = {d[7], d[7:1]};
        cf = d[0];
      end
      MODE_SWAP: begin
        r  = {d[3:0], d[7:4]};
        cf = 1'b0;
      end
      MODE_SRL: begin
        r  = {1'b0, d[7:1]};
        cf = d[0];
      end
      MODE_BIT: begin
        r  = d;
        wb = 1'b0;
        zf = ~|(d & bit_mask);
        hf = 1'b1;
        z_from_r = 1'b0;
      end
      MODE_RES: begin
        r  = d & ~bit_mask;
        nf = n;
        hf = h;
        z_from_r = 1'b0;
      end
      MODE_SET: begin
        r  = d | bit_mask;
        nf = n;
        hf = h;
        z_from_r = 1'b0;
      end
      default: begin
        // undefined selector: operand and flags pass through, no write-back
        r  = d;
        wb = 1'b0;
        nf = n;
        hf = h;
        z_from_r = 1'b0;
      end
    endcase
  end

  assign res_o.result     = r;
  assign res_o.write_back = wb;
  assign res_o.zero_out   = z_from_r ? (r == 8'd0) : zf;
  assign res_o.sub_out    = nf;
  assign res_o.half_out   = hf;
  assign res_o.carry_out  = cf;

endmodule

// ===== rtl/eight_bit_cpu_alu_with_flags_core.sv =====
// ----------------------------------------------------------------------------
// eight_bit_cpu_alu_with_flags_core: SM83-style 8-bit ALU with Z/N/H/C flags
// Path: input register, ALU logic, result register.
// Throughput one item per cycle; a stalled result blocks input once both regs are full.
// Async active-low reset empties both stages; payload registers are not reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "eight_bit_cpu_alu_with_flags_core_defines.svh"

module eight_bit_cpu_alu_with_flags_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  eba_pkg::eba_in_t   in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output eba_pkg::eba_out_t  out_item_o
);
  import eba_pkg::*;

  logic     in_valid_q;
  eba_in_t  in_item_q;
  logic     out_valid_q;
  eba_out_t out_item_q;
  eba_out_t alu_res;
  logic     out_adv;
  logic     in_take;

  assign out_adv    = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !out_adv;
  assign in_take    = in_valid_i && !in_stall_o;

  eba_alu u_alu (
    .op_i  (in_item_q),
    .res_o (alu_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (out_adv) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q <= in_item_i;
    end
    if (out_adv && in_valid_q) begin
      out_item_q <= alu_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  `EBA_ASSERT_IMP(a_stall_needs_item, clk_i, rst_ni, in_stall_o, in_valid_q && out_valid_q)
  `EBA_ASSERT_NXT(a_take_fills_stage, clk_i, rst_ni, in_take, in_valid_q)
  `EBA_ASSERT_NXT(a_move_to_out, clk_i, rst_ni, in_valid_q && out_adv, out_valid_q && (out_item_q == $past(alu_res)))
  `EBA_ASSERT_NXT(a_cp_no_wb, clk_i, rst_ni, in_valid_q && out_adv && (in_item_q.mode == MODE_CP), !out_item_q.write_back)

endmodule
